@@ src/kde_pixel_foreground_test_defines.svh @@
// ----------------------------------------------------------------------------
// kde_pixel_foreground_test_defines
// Assertion helpers for the kde pixel foreground test block.
// ----------------------------------------------------------------------------
`ifndef KDE_PIXEL_FOREGROUND_TEST_DEFINES_SVH
`define KDE_PIXEL_FOREGROUND_TEST_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KPFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kpft assertion failed");

// next-cycle implication, disabled while reset is asserted
`define KPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kpft assertion failed");

`endif

@@ src/kpft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpft_pkg
// Shared types, widths and helpers for the kde pixel foreground test block.
// ----------------------------------------------------------------------------
package kpft_pkg;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int CH_IDX_W   = 2;
	localparam int INV_W      = 24;
	localparam int TERM_W     = 32;
	localparam int MAG_W      = 48;
	localparam int MUL_B_W    = 32;
	localparam int DIGIT_W    = 4;
	localparam int CNT_W      = 4;
	localparam int PROD_W     = MAG_W + 1;
	localparam int SUM_W      = 56;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [INV_W-1:0]    INV_RESET  = 24'd65536;
	localparam logic [TERM_W:0]     ONE_Q16    = 33'd65536;
	localparam logic [CNT_W-1:0]    DIG_TERM   = 4'd4;
	localparam logic [CNT_W-1:0]    DIG_PROD   = 4'd8;
	localparam logic [CH_IDX_W-1:0] CH_LAST    = 2'd2;
	localparam logic                REG_INV_BW = 1'b0;

	localparam logic [MAG_W-1:0] CAP_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [MAG_W-1:0] CAP_NEG = 48'h8000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TERM_GO,
		ST_TERM_RUN,
		ST_P1_GO,
		ST_P1_RUN,
		ST_P2_GO,
		ST_P2_RUN,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] ndig;
	} mul_req_t;

	typedef struct packed {
		logic en;
		logic last;
	} acc_ctl_t;

	// q.16 product magnitude clamped to the signed 48-bit range
	function automatic logic [MAG_W-1:0] sat48(input logic [63:0] q, input logic neg);
		logic [MAG_W-1:0] cap;
		cap = neg ? CAP_NEG : CAP_POS;
		if (q[63:MAG_W] != '0 || q[MAG_W-1:0] > cap) begin
			return cap;
		end
		return q[MAG_W-1:0];
	endfunction

endpackage

@@ src/kpft_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpft_regs
// APB register file holding the inverse squared bandwidth.
// ----------------------------------------------------------------------------
module kpft_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kpft_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [kpft_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [kpft_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [kpft_pkg::INV_W-1:0]          inv_bw
);

	logic [kpft_pkg::INV_W-1:0] inv_q;
	logic                       reg_sel;

	assign pready  = 1'b1;
	// word index sits above the byte offset
	assign reg_sel = (paddr[kpft_pkg::APB_ADDR_W-1] == kpft_pkg::REG_INV_BW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= kpft_pkg::INV_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			inv_q <= pwdata[kpft_pkg::INV_W-1:0];
		end
	end

	assign prdata = reg_sel ? kpft_pkg::APB_DATA_W'(inv_q) : '0;
	assign inv_bw = inv_q;

endmodule

@@ src/kpft_serial_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpft_serial_mul
// Digit-serial unsigned multiplier, one 4-bit multiplier digit per cycle.
// ----------------------------------------------------------------------------
module kpft_serial_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kpft_pkg::mul_req_t                req,
	input  logic [kpft_pkg::MAG_W-1:0]        a,
	input  logic [kpft_pkg::MUL_B_W-1:0]      b,
	output logic                              done,
	output logic [kpft_pkg::MAG_W-1:0]        hi,
	output logic [kpft_pkg::MUL_B_W-1:0]      lo
);

	localparam int SUM_W = kpft_pkg::MAG_W + kpft_pkg::DIGIT_W;

	logic                          busy_q;
	logic [kpft_pkg::CNT_W-1:0]    cnt_q;
	logic [kpft_pkg::MAG_W-1:0]    a_q;
	logic [kpft_pkg::MAG_W-1:0]    hi_q;
	logic [kpft_pkg::MUL_B_W-1:0]  lo_q;
	logic [SUM_W-1:0]              step_sum;
	logic                          stepping;

	assign stepping = busy_q && (cnt_q != '0);
	assign done     = busy_q && (cnt_q == '0);

	// partial product of one digit folded into the running high half
	assign step_sum = SUM_W'(hi_q) + SUM_W'(a_q) * SUM_W'(lo_q[kpft_pkg::DIGIT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.ndig;
		end else if (stepping) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (stepping) begin
			hi_q <= step_sum[SUM_W-1:kpft_pkg::DIGIT_W];
			lo_q <= {step_sum[kpft_pkg::DIGIT_W-1:0], lo_q[kpft_pkg::MUL_B_W-1:kpft_pkg::DIGIT_W]};
		end
	end

	assign hi = hi_q;
	assign lo = lo_q;

endmodule

@@ src/kpft_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpft_accum
// Saturating 56-bit density sum and the registered mask output word.
// ----------------------------------------------------------------------------
module kpft_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kpft_pkg::acc_ctl_t                  ctl,
	input  logic signed [kpft_pkg::PROD_W-1:0]  prod,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                mask_set,
	output logic                                free
);

	localparam int SUM_W = kpft_pkg::SUM_W;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_next;
	logic                    out_valid_q;
	logic                    mask_q;

	assign sum_wide = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(prod);

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
	end

	// the output word may be replaced in the cycle it is taken
	assign free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.en) begin
				sum_q <= ctl.last ? '0 : sum_next;
			end
			if (ctl.en && ctl.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.last) begin
			mask_q <= sum_next[SUM_W-1];
		end
	end

	assign out_valid = out_valid_q;
	assign mask_set  = mask_q;

endmodule

@@ src/kde_pixel_foreground_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kde_pixel_foreground_test
// Kernel density foreground test for one pixel position, digit-serial.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid / in_stall carry one word per training sample:
//   the test pixel channels, the sample channels and last_sample.
//   output channel: out_valid / out_stall carry one mask_set word for each
//   word that had last_sample set; nothing is sent for other words.
//   apb port: register 0 (byte address 0) holds 1/h^2 in unsigned q0.24.
// Sequence: one input word is taken and worked on at a time. Each of the
//   three kernel terms goes through the shared 4-bit digit-serial multiplier
//   (4 digits), then the two q.16 products go through it (8 digits each),
//   then the saturating sum step runs and the block idles to take the next word.
// Output: mask_set is registered by the sum step of its last sample.
// Reset: the density sum clears, 1/h^2 returns to 65536, no word is pending.
// Stall: a finished mask is held in the output register while the next
//   word is taken and worked on; the sum step of a last sample waits only
//   while that register is still full and stalled.
// ----------------------------------------------------------------------------
`include "kde_pixel_foreground_test_defines.svh"

module kde_pixel_foreground_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kpft_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [kpft_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [kpft_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [kpft_pkg::CH_W-1:0]          test_ch0,
	input  logic [kpft_pkg::CH_W-1:0]          test_ch1,
	input  logic [kpft_pkg::CH_W-1:0]          test_ch2,
	input  logic [kpft_pkg::CH_W-1:0]          sample_ch0,
	input  logic [kpft_pkg::CH_W-1:0]          sample_ch1,
	input  logic [kpft_pkg::CH_W-1:0]          sample_ch2,
	input  logic                               last_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               mask_set
);

	localparam int CH_W   = kpft_pkg::CH_W;
	localparam int TERM_W = kpft_pkg::TERM_W;
	localparam int MAG_W  = kpft_pkg::MAG_W;
	localparam int B_W    = kpft_pkg::MUL_B_W;

	kpft_pkg::state_t   state_q, state_d;
	kpft_pkg::mul_req_t mul_req;
	kpft_pkg::acc_ctl_t acc_ctl;

	logic [kpft_pkg::INV_W-1:0]    inv_bw;
	logic [CH_W-1:0]               test_q   [kpft_pkg::NUM_CH];
	logic [CH_W-1:0]               sample_q [kpft_pkg::NUM_CH];
	logic                          last_q;
	logic [kpft_pkg::CH_IDX_W-1:0] ch_q;
	logic [TERM_W-1:0]             tmag_q [kpft_pkg::NUM_CH];
	logic                          tneg_q [kpft_pkg::NUM_CH];
	logic [MAG_W-1:0]              p1_mag_q;
	logic                          p1_neg_q;
	logic signed [kpft_pkg::PROD_W-1:0] prod_q;

	logic                 in_accept;
	logic [CH_W:0]        diff;
	logic [CH_W-1:0]      diff_mag;
	logic [2*CH_W-1:0]    d2;
	logic [MAG_W-1:0]     mul_a;
	logic [B_W-1:0]       mul_b;
	logic                 mul_done;
	logic [MAG_W-1:0]     mul_hi;
	logic [B_W-1:0]       mul_lo;
	logic [TERM_W-1:0]    scaled;
	logic [63:0]          prod_full;
	logic                 p1_neg;
	logic                 p2_neg;
	logic [MAG_W-1:0]     p1_sat;
	logic [MAG_W-1:0]     p2_sat;
	logic                 acc_free;

	kpft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.inv_bw  (inv_bw)
	);

	kpft_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.hi     (mul_hi),
		.lo     (mul_lo)
	);

	kpft_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (acc_ctl),
		.prod      (prod_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.mask_set  (mask_set),
		.free      (acc_free)
	);

	assign in_accept = in_valid && !in_stall;

	// squared channel difference for the channel being worked on
	assign diff     = {1'b0, test_q[ch_q]} - {1'b0, sample_q[ch_q]};
	assign diff_mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
	assign d2       = diff_mag * diff_mag;

	// (d2 * inv) >> 8 sits at bits 39:8 of the 4-digit product
	assign scaled    = {mul_hi[23:0], mul_lo[B_W-1:B_W-8]};
	// q.16 truncation of the full 8-digit product
	assign prod_full = {mul_hi, mul_lo[B_W-1:16]};
	assign p1_neg    = tneg_q[0] ^ tneg_q[1];
	assign p2_neg    = p1_neg_q ^ tneg_q[2];
	assign p1_sat    = kpft_pkg::sat48(prod_full, p1_neg);
	assign p2_sat    = kpft_pkg::sat48(prod_full, p2_neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kpft_pkg::ST_IDLE: begin
				if (in_accept) state_d = kpft_pkg::ST_TERM_GO;
			end
			kpft_pkg::ST_TERM_GO:  state_d = kpft_pkg::ST_TERM_RUN;
			kpft_pkg::ST_TERM_RUN: begin
				if (mul_done) begin
					state_d = (ch_q == kpft_pkg::CH_LAST) ? kpft_pkg::ST_P1_GO
						: kpft_pkg::ST_TERM_GO;
				end
			end
			kpft_pkg::ST_P1_GO:  state_d = kpft_pkg::ST_P1_RUN;
			kpft_pkg::ST_P1_RUN: begin
				if (mul_done) state_d = kpft_pkg::ST_P2_GO;
			end
			kpft_pkg::ST_P2_GO:  state_d = kpft_pkg::ST_P2_RUN;
			kpft_pkg::ST_P2_RUN: begin
				if (mul_done) state_d = kpft_pkg::ST_ACC;
			end
			kpft_pkg::ST_ACC: begin
				if (!last_q || acc_free) state_d = kpft_pkg::ST_IDLE;
			end
			default: state_d = kpft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		mul_req.start = 1'b0;
		mul_req.ndig  = kpft_pkg::DIG_PROD;
		mul_a         = p1_mag_q;
		mul_b         = tmag_q[2];
		acc_ctl.en    = 1'b0;
		acc_ctl.last  = last_q;
		unique case (state_q)
			kpft_pkg::ST_IDLE: in_stall = 1'b0;
			kpft_pkg::ST_TERM_GO: begin
				mul_req.start = 1'b1;
				mul_req.ndig  = kpft_pkg::DIG_TERM;
				mul_a         = MAG_W'(inv_bw);
				mul_b         = B_W'(d2);
			end
			kpft_pkg::ST_P1_GO: begin
				mul_req.start = 1'b1;
				mul_a         = MAG_W'(tmag_q[0]);
				mul_b         = tmag_q[1];
			end
			kpft_pkg::ST_P2_GO: mul_req.start = 1'b1;
			kpft_pkg::ST_ACC:   acc_ctl.en = !last_q || acc_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (in_accept) begin
			ch_q <= '0;
		end else if (state_q == kpft_pkg::ST_TERM_RUN && mul_done
			&& ch_q != kpft_pkg::CH_LAST) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			test_q[0]   <= test_ch0;
			test_q[1]   <= test_ch1;
			test_q[2]   <= test_ch2;
			sample_q[0] <= sample_ch0;
			sample_q[1] <= sample_ch1;
			sample_q[2] <= sample_ch2;
			last_q      <= last_sample;
		end
		if (state_q == kpft_pkg::ST_TERM_RUN && mul_done) begin
			// term = 1.0 - scaled, kept as sign and magnitude
			if ({1'b0, scaled} <= kpft_pkg::ONE_Q16) begin
				tmag_q[ch_q] <= TERM_W'(kpft_pkg::ONE_Q16 - {1'b0, scaled});
				tneg_q[ch_q] <= 1'b0;
			end else begin
				tmag_q[ch_q] <= TERM_W'({1'b0, scaled} - kpft_pkg::ONE_Q16);
				tneg_q[ch_q] <= 1'b1;
			end
		end
		if (state_q == kpft_pkg::ST_P1_RUN && mul_done) begin
			p1_mag_q <= p1_sat;
			p1_neg_q <= p1_neg && (p1_sat != '0);
		end
		if (state_q == kpft_pkg::ST_P2_RUN && mul_done) begin
			prod_q <= p2_neg ? -$signed({1'b0, p2_sat}) : $signed({1'b0, p2_sat});
		end
	end

	`KPFT_ASSERT_IMPL(a_mul_done_in_run, clk, arst_n, mul_done, state_q == kpft_pkg::ST_TERM_RUN || state_q == kpft_pkg::ST_P1_RUN || state_q == kpft_pkg::ST_P2_RUN)
	`KPFT_ASSERT_IMPL(a_ch_in_range, clk, arst_n, state_q == kpft_pkg::ST_TERM_GO, ch_q != 2'd3)
	`KPFT_ASSERT_NEXT(a_mask_emitted, clk, arst_n, state_q == kpft_pkg::ST_ACC && last_q && acc_free, out_valid)

endmodule

@@ bench/kpft_mask_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpft_mask_checker
// Tracks the 1/h^2 register through the apb port and keeps its own fixed-point
// kernel sum for every input word. It queues one expected mask bit per last
// sample and compares each output word against the oldest entry in the queue.
// ----------------------------------------------------------------------------
module kpft_mask_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kpft_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [kpft_pkg::APB_DATA_W-1:0]    pwdata,
	input  logic [kpft_pkg::APB_DATA_W-1:0]    prdata,
	input  logic                               pready,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [kpft_pkg::CH_W-1:0]          test_ch0,
	input  logic [kpft_pkg::CH_W-1:0]          test_ch1,
	input  logic [kpft_pkg::CH_W-1:0]          test_ch2,
	input  logic [kpft_pkg::CH_W-1:0]          sample_ch0,
	input  logic [kpft_pkg::CH_W-1:0]          sample_ch1,
	input  logic [kpft_pkg::CH_W-1:0]          sample_ch2,
	input  logic                               last_sample,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               mask_set,
	output int                                 fail_count,
	output int                                 mask_backlog
);
	import kpft_pkg::*;

	localparam logic [APB_ADDR_W-1:0] INV_BW_ADDR = APB_ADDR_W'(4 * REG_INV_BW);
	localparam longint SUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint SUM_LO = 64'shFF80_0000_0000_0000;

	logic [INV_W-1:0] inv_bw;
	longint           kde_sum;
	bit               mask_fifo[$];

	// 1 - d^2/h^2 in q.16, truncated
	function automatic longint kernel_term(input logic [CH_W-1:0] t, input logic [CH_W-1:0] s,
			input logic [INV_W-1:0] inv);
		longint      d;
		logic [63:0] scaled;
		d = longint'(t) - longint'(s);
		scaled = (64'(d * d) * 64'(inv)) >> 8;
		return 64'sd65536 - longint'(scaled);
	endfunction

	// q.16 multiply, magnitude truncated, clamped to signed 48 bits
	function automatic longint mul_q16_clamp48(input longint a, input longint b);
		logic         neg;
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [63:0]  cap;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		cap = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
		p = ({64'd0, ma} * {64'd0, mb}) >> 16;
		if (p > {64'd0, cap}) begin
			p = {64'd0, cap};
		end
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint add_clamp56(input longint a, input longint b);
		longint r;
		r = a + b;
		if (r > SUM_HI) begin
			r = SUM_HI;
		end
		if (r < SUM_LO) begin
			r = SUM_LO;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		longint prod;
		bit     want;
		if (!arst_n) begin
			inv_bw = INV_RESET;
			kde_sum = 0;
			mask_fifo.delete();
			fail_count = 0;
			mask_backlog <= 0;
		end else begin
			if (psel && penable && pready && paddr == INV_BW_ADDR) begin
				if (pwrite) begin
					inv_bw = pwdata[INV_W-1:0];
				end else if (prdata !== APB_DATA_W'(inv_bw)) begin
					$error("inv_bandwidth_sq: expected %0h, got %0h", inv_bw, prdata);
					fail_count++;
				end
			end

			if (in_valid && !in_stall) begin
				prod = mul_q16_clamp48(kernel_term(test_ch0, sample_ch0, inv_bw),
					kernel_term(test_ch1, sample_ch1, inv_bw));
				prod = mul_q16_clamp48(prod, kernel_term(test_ch2, sample_ch2, inv_bw));
				kde_sum = add_clamp56(kde_sum, prod);
				if (last_sample) begin
					mask_fifo.insert(mask_fifo.size(), kde_sum < 0);
					kde_sum = 0;
				end
			end

			if (out_valid && !out_stall) begin
				if (mask_fifo.size() == 0) begin
					$error("mask_set: expected no word, got %0b", mask_set);
					fail_count++;
				end else begin
					want = mask_fifo.pop_front();
					if (mask_set !== want) begin
						$error("mask_set: expected %0b, got %0b", want, mask_set);
						fail_count++;
					end
				end
			end

			mask_backlog <= mask_fifo.size();
		end
	end

endmodule

@@ bench/tb_kde_pixel_foreground_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kde_pixel_foreground_test
// Drives the kde foreground test block with directed pixels, a sum saturation
// run and random pixels under several bandwidth settings. Both sides idle and
// stall at random. The checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_kde_pixel_foreground_test;
	import kpft_pkg::*;

	localparam int DRAIN_CYCLES     = 48;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_WORDS      = 16;
	localparam logic [APB_ADDR_W-1:0] INV_BW_ADDR = APB_ADDR_W'(4 * REG_INV_BW);

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [APB_ADDR_W-1:0] paddr       = '0;
	logic [APB_DATA_W-1:0] pwdata      = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [CH_W-1:0]       test_ch0    = '0;
	logic [CH_W-1:0]       test_ch1    = '0;
	logic [CH_W-1:0]       test_ch2    = '0;
	logic [CH_W-1:0]       sample_ch0  = '0;
	logic [CH_W-1:0]       sample_ch1  = '0;
	logic [CH_W-1:0]       sample_ch2  = '0;
	logic                  last_sample = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  mask_set;

	int   fail_count;
	int   mask_backlog;
	int   words_sent = 0;
	bit   tx_idle_en = 1'b1;
	logic rx_idle_en = 1'b1;
	logic hold_req   = 1'b0;

	kde_pixel_foreground_test u_top (.*);

	kpft_mask_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: short random stalls, or one long hold on request
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [INV_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= INV_BW_ADDR;
		pwdata <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [CH_W-1:0] t0, input logic [CH_W-1:0] t1,
			input logic [CH_W-1:0] t2, input logic [CH_W-1:0] s0, input logic [CH_W-1:0] s1,
			input logic [CH_W-1:0] s2, input logic is_last);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		test_ch0 <= t0;
		test_ch1 <= t1;
		test_ch2 <= t2;
		sample_ch0 <= s0;
		sample_ch1 <= s1;
		sample_ch2 <= s2;
		last_sample <= is_last;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// stop offering words and let every mask and any trailing word finish
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mask_backlog != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CH_W-1:0] near_value(input logic [CH_W-1:0] center, input int spread);
		int v;
		if ($urandom_range(0, 7) == 0) begin
			return CH_W'($urandom_range(0, 255));
		end
		v = int'($urandom_range(0, 2 * spread)) - spread + int'(center);
		if (v < 0) begin
			v = 0;
		end
		if (v > 255) begin
			v = 255;
		end
		return v[CH_W-1:0];
	endfunction

	task automatic send_pixel(input int n, input int spread, input bit closed);
		logic [CH_W-1:0] t0, t1, t2;
		t0 = CH_W'($urandom_range(0, 255));
		t1 = CH_W'($urandom_range(0, 255));
		t2 = CH_W'($urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			send_word(t0, t1, t2, near_value(t0, spread), near_value(t1, spread),
				near_value(t2, spread), closed && i == n - 1);
		end
	endtask

	// reset bandwidth: h^2 = 256, so a channel difference of 16 gives a zero term
	task automatic run_directed();
		send_word(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
		send_word(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
		send_word(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
		send_word(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
		send_word(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		// one zero term makes the sum exactly zero
		send_word(8'd100, 8'd50, 8'd50, 8'd116, 8'd50, 8'd50, 1'b1);
		// slightly negative term, alone and then outweighed by a match
		send_word(8'd17, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_word(8'd17, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_word(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1);
		send_word(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_word(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		// matches pile up before one far sample
		repeat (3) send_word(8'd60, 8'd70, 8'd80, 8'd60, 8'd70, 8'd80, 1'b0);
		send_word(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
		send_word(8'hAA, 8'h55, 8'hF0, 8'h55, 8'hAA, 8'h0F, 1'b1);
		send_word(8'h0F, 8'hF0, 8'h55, 8'h0F, 8'hF0, 8'h5A, 1'b1);
	endtask

	// at max 1/h^2 products hit the 48-bit cap; 258 positive caps pin the sum at
	// its ceiling, so 256 negative caps leave exactly -1 only if it was clamped
	task automatic run_sum_ceiling();
		logic [CH_W-1:0] a, b, c;
		for (int i = 0; i < 258; i++) begin
			a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			c = CH_W'($urandom_range(0, 255));
			send_word(a, b, c, ~a, ~b, c, 1'b0);
		end
		for (int i = 0; i < 256; i++) begin
			a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			c = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			send_word(a, b, c, ~a, ~b, ~c, i == 255);
		end
	endtask

	initial begin : stimulus
		int               goal;
		int               len;
		int               spread;
		int               pixel_no;
		logic [INV_W-1:0] bw;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_pipeline();
		apb_access(1'b1, 24'hFF_FFFF);
		apb_access(1'b0, 24'h00_0000);
		run_sum_ceiling();

		for (int ph = 0; ph < 6; ph++) begin
			drain_pipeline();
			case (ph)
				0: bw = 24'd0;
				1: bw = 24'd65536;
				2: bw = 24'hFF_FFFF;
				3: bw = 24'd1;
				4: bw = INV_W'($urandom_range(0, 24'hFF_FFFF));
				default: bw = 24'd4096;
			endcase
			apb_access(1'b1, bw);
			apb_access(1'b0, 24'h00_0000);
			if (ph == 1) begin
				hold_req <= 1'b1;
			end
			if (ph == 5) begin
				tx_idle_en = 1'b0;
				rx_idle_en <= 1'b0;
			end
			goal = words_sent + PHASE_WORDS;
			pixel_no = 0;
			while (words_sent < goal) begin
				// sender waits for every pending mask mid-phase
				if (ph == 3 && pixel_no == 1) begin
					drain_pipeline();
				end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
				spread = ($urandom_range(0, 7) == 0) ? 0 : (1 << $urandom_range(0, 7));
				// some pixels lose their last mark and run into the next one
				send_pixel(len, spread, $urandom_range(0, 9) != 0);
				pixel_no++;
			end
			send_pixel(1, 4, 1'b1);
		end

		drain_pipeline();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/kpft_pkg.sv
src/kpft_regs.sv
src/kpft_serial_mul.sv
src/kpft_accum.sv
src/kde_pixel_foreground_test.sv
bench/kpft_mask_checker.sv
bench/tb_kde_pixel_foreground_test.sv
